@@ sv/tkps_pkg.sv @@
// ----------------------------------------------------------------------------
// tkps_pkg
// Shared widths, reset values and state encoding for the top-k pair selector.
// ----------------------------------------------------------------------------
package tkps_pkg;

    // fixed field widths
    localparam int SCORE_W    = 17;
    localparam int CAP_W      = 5;
    localparam int HELD_W     = 5;

    // parameter defaults
    localparam int SLOTS_DEF      = 16;
    localparam int INDEX_BITS_DEF = 20;

    // capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // input item kinds
    localparam logic KIND_OFFER = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIND,
        ST_MINOUT,
        ST_DRAIN
    } tkps_state_t;

endpackage

@@ sv/tkps_ram.sv @@
// ----------------------------------------------------------------------------
// tkps_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module tkps_ram #(
    parameter int WIDTH = 57,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/tkps_scan.sv @@
// ----------------------------------------------------------------------------
// tkps_scan
// Minimum search over slots 0 .. n-1: one read a cycle, lowest slot wins a
// tie, masked slots are skipped. Done pulses once the best entry is final.
// ----------------------------------------------------------------------------
module tkps_scan
    import tkps_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                go,
    input  logic [$clog2(SLOTS+1)-1:0]          n,
    input  logic [SLOTS-1:0]                    mask,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] raddr,
    input  logic [SCORE_W+2*INDEX_BITS-1:0]     rdata,
    output logic                                done,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] best_slot,
    output logic [SCORE_W+2*INDEX_BITS-1:0]     best_word
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int WW = SCORE_W + 2 * INDEX_BITS;

    logic [AW-1:0] addr_reg, addr_next;
    logic          active_reg, active_next;
    logic          pend_reg, pend_next;
    logic          pend_last_reg, pend_last_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic          found_reg, found_next;
    logic          done_reg, done_next;
    logic [AW-1:0] best_slot_reg, best_slot_next;
    logic [WW-1:0] best_word_reg, best_word_next;
    logic          at_end;
    logic          take;

    assign at_end = (CW'(addr_reg) + CW'(1)) == n;
    assign take   = pend_reg && !mask[pend_addr_reg] &&
                    (!found_reg ||
                     (rdata[WW-1 -: SCORE_W] < best_word_reg[WW-1 -: SCORE_W]));

    // address issue and compare
    always_comb
    begin
        addr_next      = addr_reg;
        active_next    = active_reg;
        pend_next      = 1'b0;
        pend_last_next = 1'b0;
        pend_addr_next = pend_addr_reg;
        found_next     = found_reg;
        best_slot_next = best_slot_reg;
        best_word_next = best_word_reg;
        done_next      = pend_reg && pend_last_reg;

        if (take)
        begin
            found_next     = 1'b1;
            best_slot_next = pend_addr_reg;
            best_word_next = rdata;
        end

        if (go)
        begin
            addr_next   = '0;
            active_next = 1'b1;
            found_next  = 1'b0;
        end
        else if (active_reg)
        begin
            pend_next      = 1'b1;
            pend_addr_next = addr_reg;
            pend_last_next = at_end;
            if (at_end)
            begin
                active_next = 1'b0;
            end
            else
            begin
                addr_next = addr_reg + AW'(1);
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            found_reg     <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            found_reg     <= found_next;
            done_reg      <= done_next;
        end
    end

    // address and best entry
    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        pend_addr_reg <= pend_addr_next;
        best_slot_reg <= best_slot_next;
        best_word_reg <= best_word_next;
    end

    assign raddr     = addr_reg;
    assign done      = done_reg;
    assign best_slot = best_slot_reg;
    assign best_word = best_word_reg;

endmodule

@@ sv/top_k_pair_selector.sv @@
// ----------------------------------------------------------------------------
// top_k_pair_selector
// Keeps the best-scoring record pairs in a slot RAM and drains them in order.
// ----------------------------------------------------------------------------
// An offer with a free slot below capacity needs no scan. An offer that fills
// the store, or one that is turned down at capacity, runs one minimum scan
// over the n held entries through the single RAM read port; an offer that
// replaces the minimum runs two scans. A drain runs one scan per emitted
// entry; an empty drain runs none. Results are strobes of one cycle that the
// receiver must take; busy stays high until the last result of an item is
// issued. No clearing pass follows reset.
module top_k_pair_selector
    import tkps_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // item command
    input  logic                  start,
    output logic                  busy,
    input  logic                  kind,
    input  logic [SCORE_W-1:0]    score,
    input  logic [INDEX_BITS-1:0] left_index,
    input  logic [INDEX_BITS-1:0] right_index,
    // capacity write
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CAP_W-1:0]      cfg_data,
    // results
    output logic                  result_valid,
    output logic                  accepted,
    output logic [HELD_W-1:0]     held_count,
    output logic                  is_full,
    output logic [SCORE_W-1:0]    min_score,
    output logic                  entry_valid,
    output logic [SCORE_W-1:0]    entry_score,
    output logic [INDEX_BITS-1:0] entry_left,
    output logic [INDEX_BITS-1:0] entry_right,
    output logic                  last
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int WW = SCORE_W + 2 * INDEX_BITS;

    tkps_state_t state_reg, state_next;

    logic [CAP_W-1:0]      cap_reg;
    logic [CW-1:0]         cap_eff;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         count_inc;
    logic [CW-1:0]         k_reg, k_next;
    logic [SLOTS-1:0]      used_reg, used_next;
    logic                  acc_reg, acc_next;
    logic [SCORE_W-1:0]    score_reg;
    logic [INDEX_BITS-1:0] left_reg;
    logic [INDEX_BITS-1:0] right_reg;
    logic                  take_item;

    // ram and scan connections
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [WW-1:0]         wdata;
    logic [AW-1:0]         raddr;
    logic [WW-1:0]         rdata;
    logic                  go;
    logic                  scan_done;
    logic [AW-1:0]         best_slot;
    logic [WW-1:0]         best_word;
    logic [SCORE_W-1:0]    best_score;

    // result register file
    logic                  res_valid_reg, res_valid_next;
    logic                  res_acc_reg, res_acc_next;
    logic [HELD_W-1:0]     res_held_reg, res_held_next;
    logic                  res_full_reg, res_full_next;
    logic [SCORE_W-1:0]    res_min_reg, res_min_next;
    logic                  res_ev_reg, res_ev_next;
    logic [SCORE_W-1:0]    res_es_reg, res_es_next;
    logic [INDEX_BITS-1:0] res_el_reg, res_el_next;
    logic [INDEX_BITS-1:0] res_er_reg, res_er_next;
    logic                  res_last_reg, res_last_next;

    assign busy       = (state_reg != ST_IDLE);
    assign take_item  = start && !busy;
    assign cfg_ready  = 1'b1;
    assign count_inc  = count_reg + CW'(1);
    assign best_score = best_word[WW-1 -: SCORE_W];

    // effective capacity, clamped to 1 .. SLOTS
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (int'(cap_reg) > SLOTS)
        begin
            cap_eff = CW'(SLOTS);
        end
        else
        begin
            cap_eff = CW'(cap_reg);
        end
    end

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_reg <= cfg_data;
        end
    end

    tkps_ram #(
        .WIDTH (WW),
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    tkps_scan #(
        .SLOTS      (SLOTS),
        .INDEX_BITS (INDEX_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .n         (count_reg),
        .mask      (used_reg),
        .raddr     (raddr),
        .rdata     (rdata),
        .done      (scan_done),
        .best_slot (best_slot),
        .best_word (best_word)
    );

    // sequencer: next state, ram writes and result
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        used_next      = used_reg;
        acc_next       = acc_reg;
        go             = 1'b0;
        we             = 1'b0;
        waddr          = best_slot;
        wdata          = {score_reg, left_reg, right_reg};
        res_valid_next = 1'b0;
        res_acc_next   = 1'b0;
        res_held_next  = '0;
        res_full_next  = 1'b0;
        res_min_next   = '0;
        res_ev_next    = 1'b0;
        res_es_next    = '0;
        res_el_next    = '0;
        res_er_next    = '0;
        res_last_next  = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take_item)
                begin
                    if (kind == KIND_OFFER)
                    begin
                        if (count_reg < cap_eff)
                        begin
                            // free slot: append at the fill position
                            we         = 1'b1;
                            waddr      = AW'(count_reg);
                            wdata      = {score, left_index, right_index};
                            count_next = count_inc;
                            acc_next   = 1'b1;
                            if (count_inc >= cap_eff)
                            begin
                                go         = 1'b1;
                                state_next = ST_MINOUT;
                            end
                            else
                            begin
                                res_valid_next = 1'b1;
                                res_acc_next   = 1'b1;
                                res_held_next  = HELD_W'(count_inc);
                            end
                        end
                        else
                        begin
                            acc_next   = 1'b0;
                            go         = 1'b1;
                            state_next = ST_FIND;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        // drain of an empty store
                        res_valid_next = 1'b1;
                    end
                    else
                    begin
                        k_next     = '0;
                        used_next  = '0;
                        go         = 1'b1;
                        state_next = ST_DRAIN;
                    end
                end
            end

            ST_FIND:
            begin
                if (scan_done)
                begin
                    if (score_reg > best_score)
                    begin
                        // replace the minimum, then find the new one
                        we         = 1'b1;
                        acc_next   = 1'b1;
                        go         = 1'b1;
                        state_next = ST_MINOUT;
                    end
                    else
                    begin
                        res_valid_next = 1'b1;
                        res_held_next  = HELD_W'(count_reg);
                        res_full_next  = 1'b1;
                        res_min_next   = best_score;
                        state_next     = ST_IDLE;
                    end
                end
            end

            ST_MINOUT:
            begin
                if (scan_done)
                begin
                    res_valid_next = 1'b1;
                    res_acc_next   = acc_reg;
                    res_held_next  = HELD_W'(count_reg);
                    res_full_next  = 1'b1;
                    res_min_next   = best_score;
                    state_next     = ST_IDLE;
                end
            end

            ST_DRAIN:
            begin
                if (scan_done)
                begin
                    res_valid_next       = 1'b1;
                    res_ev_next          = 1'b1;
                    res_es_next          = best_score;
                    res_el_next          = best_word[2*INDEX_BITS-1 -: INDEX_BITS];
                    res_er_next          = best_word[INDEX_BITS-1:0];
                    res_last_next        = ((k_reg + CW'(1)) == count_reg);
                    used_next[best_slot] = 1'b1;
                    if ((k_reg + CW'(1)) == count_reg)
                    begin
                        count_next = '0;
                        used_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + CW'(1);
                        go     = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            k_reg         <= '0;
            used_reg      <= '0;
            acc_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            used_reg      <= used_next;
            acc_reg       <= acc_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            score_reg <= score;
            left_reg  <= left_index;
            right_reg <= right_index;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (res_valid_next)
        begin
            res_acc_reg  <= res_acc_next;
            res_held_reg <= res_held_next;
            res_full_reg <= res_full_next;
            res_min_reg  <= res_min_next;
            res_ev_reg   <= res_ev_next;
            res_es_reg   <= res_es_next;
            res_el_reg   <= res_el_next;
            res_er_reg   <= res_er_next;
            res_last_reg <= res_last_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign accepted     = res_acc_reg;
    assign held_count   = res_held_reg;
    assign is_full      = res_full_reg;
    assign min_score    = res_min_reg;
    assign entry_valid  = res_ev_reg;
    assign entry_score  = res_es_reg;
    assign entry_left   = res_el_reg;
    assign entry_right  = res_er_reg;
    assign last         = res_last_reg;

endmodule

@@ dv/tb_top_k_pair_selector.sv @@
// ----------------------------------------------------------------------------
// tb_top_k_pair_selector
// Self-checking testbench for the top-k pair selector. A short table of
// directed offers, drains and capacity writes is followed by random phases,
// each with its own capacity. Every transfer runs through a predictor that
// tracks the held pairs; each result strobe is checked field by field
// against the oldest expected result.
// ----------------------------------------------------------------------------
module tb_top_k_pair_selector;
    import tkps_pkg::*;

    localparam int SLOTS        = SLOTS_DEF;
    localparam int IDX_W        = INDEX_BITS_DEF;
    localparam int RANDOM_ITEMS = 200;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct packed {
        logic                 accepted;
        logic [HELD_W-1:0]    held_count;
        logic                 is_full;
        logic [SCORE_W-1:0]   min_score;
        logic                 entry_valid;
        logic [SCORE_W-1:0]   entry_score;
        logic [IDX_W-1:0]     entry_left;
        logic [IDX_W-1:0]     entry_right;
        logic                 last;
    } pair_result_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CAP
    } row_op_t;

    typedef struct {
        row_op_t            op;
        logic               kind;
        logic [SCORE_W-1:0] score;
        logic [IDX_W-1:0]   left;
        logic [IDX_W-1:0]   right;
        logic [CAP_W-1:0]   cap;
        bit                 typed;
        pair_result_t       want;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                kind;
    logic [SCORE_W-1:0]  score;
    logic [IDX_W-1:0]    left_index;
    logic [IDX_W-1:0]    right_index;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CAP_W-1:0]    cfg_data;
    logic                result_valid;
    logic                accepted;
    logic [HELD_W-1:0]   held_count;
    logic                is_full;
    logic [SCORE_W-1:0]  min_score;
    logic                entry_valid;
    logic [SCORE_W-1:0]  entry_score;
    logic [IDX_W-1:0]    entry_left;
    logic [IDX_W-1:0]    entry_right;
    logic                last;

    // predictor state: held pairs and the capacity register
    logic [SCORE_W-1:0]  pair_score [SLOTS];
    logic [IDX_W-1:0]    pair_left  [SLOTS];
    logic [IDX_W-1:0]    pair_right [SLOTS];
    int                  pairs_held;
    logic [CAP_W-1:0]    capacity_reg;

    pair_result_t        pending_results [$];
    stim_row_t           directed_rows [$];
    int                  mismatch_count = 0;
    int                  cycle_count = 0;
    bit                  burst_mode = 0;

    top_k_pair_selector #(
        .SLOTS      (SLOTS),
        .INDEX_BITS (IDX_W)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .score        (score),
        .left_index   (left_index),
        .right_index  (right_index),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .accepted     (accepted),
        .held_count   (held_count),
        .is_full      (is_full),
        .min_score    (min_score),
        .entry_valid  (entry_valid),
        .entry_score  (entry_score),
        .entry_left   (entry_left),
        .entry_right  (entry_right),
        .last         (last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // capacity as the block applies it: 0 acts as 1, above SLOTS as SLOTS
    function automatic int effective_capacity();
        int c;
        c = capacity_reg;
        if (c == 0) c = 1;
        if (c > SLOTS) c = SLOTS;
        return c;
    endfunction

    // lowest slot that holds the smallest score
    function automatic int weakest_slot();
        int best;
        best = 0;
        for (int i = 1; i < pairs_held; i++)
            if (pair_score[i] < pair_score[best]) best = i;
        return best;
    endfunction

    function automatic pair_result_t offer_result(logic acc, int held, logic full,
                                                  logic [SCORE_W-1:0] minv);
        pair_result_t r;
        r = '0;
        r.accepted   = acc;
        r.held_count = HELD_W'(held);
        r.is_full    = full;
        r.min_score  = minv;
        r.last       = 1'b1;
        return r;
    endfunction

    // work out the results of one transfer and queue them
    function automatic void predict_pairs(logic k, logic [SCORE_W-1:0] s,
                                          logic [IDX_W-1:0] l, logic [IDX_W-1:0] r);
        int           cap;
        int           m;
        int           best;
        logic         acc;
        logic         full;
        logic [SLOTS-1:0] used;
        pair_result_t res;
        cap = effective_capacity();
        if (k == KIND_OFFER)
        begin
            acc = 1'b0;
            if (pairs_held < cap)
            begin
                pair_score[pairs_held] = s;
                pair_left[pairs_held]  = l;
                pair_right[pairs_held] = r;
                pairs_held++;
                acc = 1'b1;
            end
            else if (pairs_held > 0)
            begin
                m = weakest_slot();
                if (s > pair_score[m])
                begin
                    pair_score[m] = s;
                    pair_left[m]  = l;
                    pair_right[m] = r;
                    acc = 1'b1;
                end
            end
            full = (pairs_held >= cap);
            pending_results.push_back(offer_result(acc, pairs_held, full,
                (full && pairs_held > 0) ? pair_score[weakest_slot()] : '0));
        end
        else if (pairs_held == 0)
        begin
            pending_results.push_back(offer_result(1'b0, 0, 1'b0, '0));
        end
        else
        begin
            // ascending score, equal scores in slot order
            used = '0;
            for (int n = 0; n < pairs_held; n++)
            begin
                best = -1;
                for (int i = 0; i < pairs_held; i++)
                    if (!used[i] && (best < 0 || pair_score[i] < pair_score[best]))
                        best = i;
                used[best] = 1'b1;
                res = '0;
                res.entry_valid = 1'b1;
                res.entry_score = pair_score[best];
                res.entry_left  = pair_left[best];
                res.entry_right = pair_right[best];
                res.last        = (n == pairs_held - 1);
                pending_results.push_back(res);
            end
            pairs_held = 0;
        end
    endfunction

    // result check, one strobe per cycle
    always @(posedge clk)
    begin : result_check
        pair_result_t want;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result strobe with nothing expected");
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("accepted", 32'(accepted), 32'(want.accepted));
                check_field("held_count", 32'(held_count), 32'(want.held_count));
                check_field("is_full", 32'(is_full), 32'(want.is_full));
                check_field("min_score", 32'(min_score), 32'(want.min_score));
                check_field("entry_valid", 32'(entry_valid), 32'(want.entry_valid));
                check_field("entry_score", 32'(entry_score), 32'(want.entry_score));
                check_field("entry_left", 32'(entry_left), 32'(want.entry_left));
                check_field("entry_right", 32'(entry_right), 32'(want.entry_right));
                check_field("last", 32'(last), 32'(want.last));
            end
        end
    end

    function automatic int pick_gap();
        if (burst_mode) return 0;
        case ($urandom_range(0, 9))
            5, 6, 7: return $urandom_range(1, 3);
            8:       return $urandom_range(4, 8);
            9:       return $urandom_range(20, 60);
            default: return 0;
        endcase
    endfunction

    // one command transfer; start stays high when no gap follows
    task automatic send_item(logic k, logic [SCORE_W-1:0] s, logic [IDX_W-1:0] l,
                             logic [IDX_W-1:0] r, bit typed, pair_result_t want);
        int gap;
        start       <= 1'b1;
        kind        <= k;
        score       <= s;
        left_index  <= l;
        right_index <= r;
        do
            @(posedge clk);
        while (busy);
        predict_pairs(k, s, l, r);
        if (typed)
        begin
            void'(pending_results.pop_back());
            pending_results.push_back(want);
        end
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        capacity_reg = v;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SCORE_W-1:0] random_score();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return SCORE_W'($urandom_range(0, 7));
            4, 5, 6:    return SCORE_W'($urandom);
            7:          return SCORE_W'($urandom_range(0, 2) == 0 ? 0 : 65536 +
                                        $urandom_range(0, 1) * 65535);
            default:    return SCORE_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] random_index();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return IDX_W'($urandom);
        endcase
    endfunction

    function automatic stim_row_t item_row(logic k, logic [SCORE_W-1:0] s,
                                           logic [IDX_W-1:0] l, logic [IDX_W-1:0] r);
        stim_row_t row;
        row       = '{op: ROW_ITEM, kind: k, score: s, left: l, right: r, cap: '0,
                      typed: 1'b0, want: '0};
        return row;
    endfunction

    function automatic stim_row_t checked_row(logic k, logic [SCORE_W-1:0] s,
                                              logic [IDX_W-1:0] l, logic [IDX_W-1:0] r,
                                              pair_result_t want);
        stim_row_t row;
        row       = item_row(k, s, l, r);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic stim_row_t cap_row(logic [CAP_W-1:0] v);
        stim_row_t row;
        row     = item_row(KIND_OFFER, '0, '0, '0);
        row.op  = ROW_CAP;
        row.cap = v;
        return row;
    endfunction

    // stimulus
    initial
    begin
        int          phase;
        int          burst_len;
        int          random_count;
        int          cap_plan [7];
        pair_result_t no_result;
        cap_plan     = '{16, 0, 31, 1, 17, 2, 3};
        no_result    = '0;
        rst_n        = 1'b0;
        start        = 1'b0;
        kind         = KIND_OFFER;
        score        = '0;
        left_index   = '0;
        right_index  = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        pairs_held   = 0;
        capacity_reg = CAP_RESET;
        for (int i = 0; i < SLOTS; i++)
        begin
            pair_score[i] = '0;
            pair_left[i]  = '0;
            pair_right[i] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: empty drain, field extremes, capacity corners and ties
        directed_rows.push_back(checked_row(KIND_DRAIN, '0, '0, '0,
                                            offer_result(0, 0, 0, '0)));
        directed_rows.push_back(checked_row(KIND_OFFER, '0, '0, '0,
                                            offer_result(1, 1, 0, '0)));
        directed_rows.push_back(checked_row(KIND_OFFER, '1, '1, '1,
                                            offer_result(1, 2, 0, '0)));
        directed_rows.push_back(item_row(KIND_DRAIN, '0, '0, '0));
        directed_rows.push_back(cap_row(5'd0));
        directed_rows.push_back(checked_row(KIND_OFFER, 17'd100, 20'd1, 20'd1,
                                            offer_result(1, 1, 1, 17'd100)));
        directed_rows.push_back(checked_row(KIND_OFFER, 17'd100, 20'd2, 20'd2,
                                            offer_result(0, 1, 1, 17'd100)));
        directed_rows.push_back(item_row(KIND_OFFER, 17'd101, 20'd3, 20'd3));
        directed_rows.push_back(item_row(KIND_DRAIN, '0, '0, '0));
        directed_rows.push_back(cap_row(5'd3));
        directed_rows.push_back(item_row(KIND_OFFER, 17'd50, 20'd10, 20'h0aaaa));
        directed_rows.push_back(item_row(KIND_OFFER, 17'd50, 20'd11, 20'h55555));
        directed_rows.push_back(item_row(KIND_OFFER, 17'd50, 20'd12, 20'd12));
        directed_rows.push_back(item_row(KIND_OFFER, 17'd60, 20'd13, 20'd13));
        // capacity below the held count: store stays, offers compete
        directed_rows.push_back(cap_row(5'd1));
        directed_rows.push_back(item_row(KIND_OFFER, 17'd55, 20'd14, 20'd14));
        directed_rows.push_back(item_row(KIND_OFFER, 17'd40, 20'd15, 20'd15));
        directed_rows.push_back(item_row(KIND_DRAIN, '0, '0, '0));
        directed_rows.push_back(cap_row(5'd31));
        directed_rows.push_back(checked_row(KIND_DRAIN, '0, '0, '0,
                                            offer_result(0, 0, 0, '0)));
        directed_rows.push_back(checked_row(KIND_OFFER, 17'd65536, 20'hfffff, '0,
                                            offer_result(1, 1, 0, '0)));
        directed_rows.push_back(item_row(KIND_OFFER, 17'd65535, '0, 20'hfffff));
        directed_rows.push_back(item_row(KIND_DRAIN, '0, '0, '0));

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].op == ROW_CAP)
                write_capacity(directed_rows[i].cap);
            else
                send_item(directed_rows[i].kind, directed_rows[i].score,
                          directed_rows[i].left, directed_rows[i].right,
                          directed_rows[i].typed, directed_rows[i].want);
        end

        // random phases, each with its own capacity and idling pattern
        phase        = 0;
        random_count = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            write_capacity(phase < 7 ? CAP_W'(cap_plan[phase]) : CAP_W'($urandom_range(0, 31)));
            burst_mode = ($urandom_range(0, 3) == 0);
            burst_len  = $urandom_range(1, 30);
            repeat (burst_len)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_item(KIND_DRAIN, random_score(), random_index(), random_index(),
                              1'b0, no_result);
                else
                    send_item(KIND_OFFER, random_score(), random_index(), random_index(),
                              1'b0, no_result);
                random_count++;
            end
            if ($urandom_range(0, 4) != 0)
            begin
                send_item(KIND_DRAIN, random_score(), random_index(), random_index(),
                          1'b0, no_result);
                random_count++;
            end
            phase++;
        end
        burst_mode = 0;

        // drain the expected results, then let the block settle
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
